>>> design/gne_pkg.sv
// shared widths, codes and types of the grid neighbor index enumerator
`timescale 1ns / 1ps

package gne_pkg;

    localparam int IDX_W     = 30;                 // linear voxel index
    localparam int SIDE_W    = 11;                 // size register
    localparam int CODE_W    = 5;                  // offset code
    localparam int MAX_SIDE  = 1024;               // largest usable side
    localparam int CW        = $clog2(MAX_SIDE);   // one coordinate
    localparam int PLANE_W   = 2 * CW + 1;         // size_x * size_y
    localparam int TOTAL_W   = 3 * CW + 1;         // size_x * size_y * size_z
    localparam int CNT_W     = $clog2(CW);         // divider step count
    localparam int CFG_IDX_W = 2;
    localparam int SETTLE_W  = 2;
    localparam int QDEPTH    = 2;
    localparam int QA_W      = $clog2(QDEPTH);
    localparam int QC_W      = $clog2(QDEPTH + 1);

    localparam logic [CODE_W-1:0] LAST_CODE = CODE_W'(26);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    // cycles after a size write until the derived values are good
    localparam logic [SETTLE_W-1:0] SETTLE_CYC = 2'd2;

    typedef struct packed {
        logic [SIDE_W-1:0]  sx;
        logic [SIDE_W-1:0]  sy;
        logic [SIDE_W-1:0]  sz;
        logic [PLANE_W-1:0] plane;
        logic [TOTAL_W-1:0] total;
        logic [IDX_W-1:0]   inc_z;      // step to the next dz
        logic [IDX_W-1:0]   inc_y;      // dz wraps, dy steps
        logic [IDX_W-1:0]   inc_x;      // dz and dy wrap, dx steps
        logic [IDX_W-1:0]   start_off;  // center to the (-1,-1,-1) corner
    } t_geom;

    typedef struct packed {
        logic x_lo;
        logic x_hi;
        logic y_lo;
        logic y_hi;
        logic z_lo;
        logic z_hi;
    } t_edges;

    typedef struct packed {
        logic             bad;
        logic [IDX_W-1:0] start;
        t_edges           edges;
    } t_job;

endpackage

>>> design/gne_in_if.sv
// input channel: one center voxel index per word
`timescale 1ns / 1ps

interface gne_in_if
    import gne_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] voxel_index;

    modport source (output valid, output voxel_index, input ready);
    modport sink (input valid, input voxel_index, output ready);
endinterface

>>> design/gne_out_if.sv
// output channel: one neighbor result per word
`timescale 1ns / 1ps

interface gne_out_if
    import gne_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  neighbor_index;
    logic [CODE_W-1:0] offset_code;
    logic              last_of_run;
    logic              bad_index;

    modport source (output valid, output neighbor_index, output offset_code,
                    output last_of_run, output bad_index, input ready);
    modport sink (input valid, input neighbor_index, input offset_code,
                  input last_of_run, input bad_index, output ready);
endinterface

>>> design/gne_cfg.sv
// size registers and the grid constants derived from them
`timescale 1ns / 1ps

module gne_cfg
    import gne_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIDE_W-1:0]    i_cfg_data,
    output t_geom                o_geom,
    output logic                 o_busy
);

    logic [SIDE_W-1:0]   r_sx;
    logic [SIDE_W-1:0]   r_sy;
    logic [SIDE_W-1:0]   r_sz;
    logic [SETTLE_W-1:0] r_settle;
    logic [PLANE_W-1:0]  r_plane;
    logic [TOTAL_W-1:0]  r_total;
    logic [IDX_W-1:0]    r_inc_z;
    logic [IDX_W-1:0]    r_inc_y;
    logic [IDX_W-1:0]    r_inc_x;
    logic [IDX_W-1:0]    r_start_off;
    logic [SIDE_W-1:0]   side;
    logic [IDX_W-1:0]    plane_w;
    logic [IDX_W-1:0]    nx_w;

    // clamp to the largest side
    assign side = (i_cfg_data > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx     <= SIDE_W'(1);
            r_sy     <= SIDE_W'(1);
            r_sz     <= SIDE_W'(1);
            r_settle <= SETTLE_CYC;
        end else begin
            if (i_cfg_we) begin
                r_settle <= SETTLE_CYC;
                case (i_cfg_idx)
                    REG_SIZE_X: r_sx <= side;
                    REG_SIZE_Y: r_sy <= side;
                    REG_SIZE_Z: r_sz <= side;
                    default: ;
                endcase
            end else if (r_settle != '0) begin
                r_settle <= r_settle - SETTLE_W'(1);
            end
        end
    end

    assign plane_w = IDX_W'(r_plane);
    assign nx_w    = IDX_W'(r_sx);

    // two register levels: plane first, then everything built on it
    always_ff @(posedge i_clk) begin
        r_plane     <= PLANE_W'(r_sx) * PLANE_W'(r_sy);
        r_total     <= TOTAL_W'(r_plane) * TOTAL_W'(r_sz);
        r_inc_z     <= plane_w;
        r_inc_y     <= nx_w - (plane_w << 1);
        r_inc_x     <= IDX_W'(1) - (nx_w << 1) - (plane_w << 1);
        r_start_off <= '0 - IDX_W'(1) - nx_w - plane_w;
    end

    assign o_busy          = (r_settle != '0);
    assign o_geom.sx        = r_sx;
    assign o_geom.sy        = r_sy;
    assign o_geom.sz        = r_sz;
    assign o_geom.plane     = r_plane;
    assign o_geom.total     = r_total;
    assign o_geom.inc_z     = r_inc_z;
    assign o_geom.inc_y     = r_inc_y;
    assign o_geom.inc_x     = r_inc_x;
    assign o_geom.start_off = r_start_off;

endmodule

>>> design/gne_front.sv
// front end: takes a word, checks range, splits the index into x, y, z
`timescale 1ns / 1ps

module gne_front
    import gne_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_geom i_geom,
    input  logic  i_cfg_busy,
    gne_in_if.sink i_vox,
    output logic  o_push,
    output t_job  o_job,
    input  logic  i_full
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIVZ = 2'd1;
    localparam logic [1:0] S_DIVY = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic [IDX_W-1:0]   r_rem;
    logic [IDX_W-1:0]   n_rem;
    logic [TOTAL_W-1:0] r_dv;
    logic [TOTAL_W-1:0] n_dv;
    logic [CW-1:0]      r_q;
    logic [CW-1:0]      n_q;
    logic [CW-1:0]      r_zq;
    logic [CW-1:0]      n_zq;
    logic               r_bad;
    logic               n_bad;
    logic [IDX_W-1:0]   r_start;
    logic [IDX_W-1:0]   n_start;
    logic               accept;
    logic               ge;
    logic [CW-1:0]      q_next;
    logic [CW-1:0]      cx;

    assign i_vox.ready = (r_state == S_IDLE) && !i_cfg_busy;
    assign accept      = i_vox.valid && i_vox.ready;

    // one restoring division step per cycle
    assign ge     = ({1'b0, r_rem} >= r_dv);
    assign q_next = {r_q[CW-2:0], ge};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_dv    = r_dv;
        n_q     = r_q;
        n_zq    = r_zq;
        n_bad   = r_bad;
        n_start = r_start;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rem   = i_vox.voxel_index;
                    n_dv    = TOTAL_W'(i_geom.plane) << (CW - 1);
                    n_bad   = ({1'b0, i_vox.voxel_index} >= i_geom.total);
                    n_start = i_vox.voxel_index + i_geom.start_off;
                    n_cnt   = '0;
                    n_state = n_bad ? S_PUSH : S_DIVZ;
                end
            end
            S_DIVZ, S_DIVY: begin
                if (ge) begin
                    n_rem = r_rem - r_dv[IDX_W-1:0];
                end
                n_q   = q_next;
                n_dv  = r_dv >> 1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CW - 1)) begin
                    n_cnt = '0;
                    if (r_state == S_DIVZ) begin
                        n_zq    = q_next;
                        n_dv    = TOTAL_W'(i_geom.sx) << (CW - 1);
                        n_state = S_DIVY;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                if (!i_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_dv    <= n_dv;
        r_q     <= n_q;
        r_zq    <= n_zq;
        r_bad   <= n_bad;
        r_start <= n_start;
    end

    // x is what remains after the y division
    assign cx = r_rem[CW-1:0];

    assign o_push         = (r_state == S_PUSH) && !i_full;
    assign o_job.bad      = r_bad;
    assign o_job.start    = r_start;
    assign o_job.edges.x_lo = (cx != '0);
    assign o_job.edges.x_hi = ((SIDE_W'(cx) + SIDE_W'(1)) < i_geom.sx);
    assign o_job.edges.y_lo = (r_q != '0);
    assign o_job.edges.y_hi = ((SIDE_W'(r_q) + SIDE_W'(1)) < i_geom.sy);
    assign o_job.edges.z_lo = (r_zq != '0);
    assign o_job.edges.z_hi = ((SIDE_W'(r_zq) + SIDE_W'(1)) < i_geom.sz);

endmodule

>>> design/gne_queue.sv
// short job queue between front and back
`timescale 1ns / 1ps

module gne_queue
    import gne_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job            r_mem [QDEPTH];
    logic [QA_W-1:0] r_wp;
    logic [QA_W-1:0] r_rp;
    logic [QC_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QC_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QA_W'(QDEPTH - 1)) ? '0 : r_wp + QA_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QA_W'(QDEPTH - 1)) ? '0 : r_rp + QA_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QC_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

>>> design/gne_back.sv
// back end: walks the 27 offsets in order up to the last in-grid one and drives the output register
`timescale 1ns / 1ps

module gne_back
    import gne_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_geom i_geom,
    input  logic  i_valid,
    input  t_job  i_job,
    output logic  o_pop,
    gne_out_if.source o_nbr
);

    localparam logic [1:0] OFF_NEG = 2'd0;
    localparam logic [1:0] OFF_MID = 2'd1;
    localparam logic [1:0] OFF_POS = 2'd2;

    logic              r_busy;
    logic              r_bad;
    t_edges            r_edges;
    logic [IDX_W-1:0]  r_lin;
    logic [CODE_W-1:0] r_code;
    logic [1:0]        r_dx;
    logic [1:0]        r_dy;
    logic [1:0]        r_dz;
    logic              r_ov;
    logic [IDX_W-1:0]  r_o_idx;
    logic [CODE_W-1:0] r_o_code;
    logic              r_o_last;
    logic              r_o_bad;
    logic              step_ok;
    logic              at_last;
    logic              can_load;
    logic              advance;
    logic              finish;
    logic [IDX_W-1:0]  inc;

    function automatic logic axis_ok(input logic [1:0] d, input logic lo, input logic hi);
        logic ok;
        case (d)
            OFF_NEG: ok = lo;
            OFF_POS: ok = hi;
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

    function automatic logic [1:0] axis_max(input logic hi);
        return hi ? OFF_POS : OFF_MID;
    endfunction

    assign step_ok = axis_ok(r_dx, r_edges.x_lo, r_edges.x_hi)
                  && axis_ok(r_dy, r_edges.y_lo, r_edges.y_hi)
                  && axis_ok(r_dz, r_edges.z_lo, r_edges.z_hi);

    // the last in-grid offset ends the run
    assign at_last = (r_dx == axis_max(r_edges.x_hi))
                  && (r_dy == axis_max(r_edges.y_hi))
                  && (r_dz == axis_max(r_edges.z_hi));

    assign can_load = !r_ov || o_nbr.ready;
    assign advance  = r_busy && can_load;
    assign finish   = advance && (r_bad || at_last);
    assign o_pop    = i_valid && (!r_busy || finish);

    assign inc = (r_dz != OFF_POS) ? i_geom.inc_z :
                 (r_dy != OFF_POS) ? i_geom.inc_y : i_geom.inc_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (advance && (r_bad || step_ok)) begin
                r_ov <= 1'b1;
            end else if (o_nbr.ready) begin
                r_ov <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bad   <= i_job.bad;
            r_edges <= i_job.edges;
            r_lin   <= i_job.start;
            r_code  <= '0;
            r_dx    <= OFF_NEG;
            r_dy    <= OFF_NEG;
            r_dz    <= OFF_NEG;
        end else if (advance && !r_bad) begin
            r_lin  <= r_lin + inc;
            r_code <= r_code + CODE_W'(1);
            if (r_dz != OFF_POS) begin
                r_dz <= r_dz + 2'd1;
            end else begin
                r_dz <= OFF_NEG;
                if (r_dy != OFF_POS) begin
                    r_dy <= r_dy + 2'd1;
                end else begin
                    r_dy <= OFF_NEG;
                    r_dx <= r_dx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (r_bad) begin
                r_o_idx  <= '0;
                r_o_code <= '0;
                r_o_last <= 1'b1;
                r_o_bad  <= 1'b1;
            end else if (step_ok) begin
                r_o_idx  <= r_lin;
                r_o_code <= r_code;
                r_o_last <= at_last;
                r_o_bad  <= 1'b0;
            end
        end
    end

    assign o_nbr.valid          = r_ov;
    assign o_nbr.neighbor_index = r_o_idx;
    assign o_nbr.offset_code    = r_o_code;
    assign o_nbr.last_of_run    = r_o_last;
    assign o_nbr.bad_index      = r_o_bad;

endmodule

>>> design/grid_neighbor_index_enumerator.sv
// top level of the grid neighbor index enumerator
`timescale 1ns / 1ps

// Takes a linear voxel index into a size_x by size_y by size_z grid (x fastest,
// then y, then z) and returns the linear index of every in-grid voxel of its
// 3x3x3 neighborhood, center included, in the order dx outer, dy middle, dz
// inner, each going -1, 0, +1. Each result word carries the offset code
// (dx+1)*9 + (dy+1)*3 + (dz+1); the final word of a run has last_of_run set.
// An index at or beyond size_x*size_y*size_z gives a single word with
// bad_index and last_of_run set and zero index and code. Sizes above 1024 are
// taken as 1024 and a size of zero makes every index bad; the largest grid,
// of 2^30 voxels, still fits the 30-bit index.
// The front end checks the range of a word, then runs a restoring divider
// giving one bit of z and then one bit of y per cycle; a bad index skips the
// divider. The back end visits one offset code per cycle while the output is
// not stalled, emitting the in-grid ones, and stops at the last in-grid
// neighbor; a bad index gives its single word. A two-entry queue lets the
// front divide the next word while the back is still enumerating, so the
// sustained rate for in-grid words is that of the slower of the two ends. An
// output register parts the result channel from the enumerator. After reset
// and after every size write the input stays not ready while the plane and
// volume products are rebuilt.

module grid_neighbor_index_enumerator
    import gne_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // size registers: size_x, size_y, size_z
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIDE_W-1:0]    i_cfg_data,
    // center voxel words in, neighbor words out
    gne_in_if.sink               i_vox,
    gne_out_if.source            o_nbr
);

    t_geom geom;
    logic  cfg_busy;
    logic  push;
    t_job  push_job;
    logic  q_full;
    logic  q_valid;
    t_job  q_job;
    logic  pop;

    // size registers plus plane, volume and walk increments
    gne_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_geom     (geom),
        .o_busy     (cfg_busy)
    );

    // range check and coordinate split
    gne_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_geom     (geom),
        .i_cfg_busy (cfg_busy),
        .i_vox      (i_vox),
        .o_push     (push),
        .o_job      (push_job),
        .i_full     (q_full)
    );

    // jobs: bad flag, start index of the corner neighbor and the low and high edge flags of x, y and z
    gne_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    // offset walk, one add per step, and the output register
    gne_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_nbr   (o_nbr)
    );

endmodule

>>> design/gne_checker.sv
// port level checks of the grid neighbor index enumerator
`timescale 1ns / 1ps

module gne_checker
    import gne_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_we,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [IDX_W-1:0]  i_out_index,
    input logic [CODE_W-1:0] i_out_code,
    input logic              i_out_last,
    input logic              i_out_bad
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_index)
            && $stable(i_out_code) && $stable(i_out_last) && $stable(i_out_bad))
        else $error("result word changed while stalled");

    // a bad index is a one-word run with zero payload
    a_bad_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_bad |-> i_out_last && (i_out_index == '0)
            && (i_out_code == '0))
        else $error("bad index word malformed");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_code <= LAST_CODE))
        else $error("offset code out of range");

    // no word is taken while the grid products are being rebuilt
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !i_in_ready)
        else $error("input ready right after a size write");

endmodule

bind grid_neighbor_index_enumerator gne_checker u_gne_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_in_ready  (i_vox.ready),
    .i_out_valid (o_nbr.valid),
    .i_out_ready (o_nbr.ready),
    .i_out_index (o_nbr.neighbor_index),
    .i_out_code  (o_nbr.offset_code),
    .i_out_last  (o_nbr.last_of_run),
    .i_out_bad   (o_nbr.bad_index)
);
